// ----- rtl/jvm_integer_alu_macros.svh -----
// Assertion macros for the JVM integer ALU.
// Included by the RTL files that carry concurrent assertions.
`ifndef JVM_INTEGER_ALU_MACROS_SVH
`define JVM_INTEGER_ALU_MACROS_SVH

// Property clocked on clk_i and disabled while reset is asserted.
`define JIA_PROP(prop) @(posedge clk_i) disable iff (!rst_ni) (prop)

`define JIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (`JIA_PROP(prop)) else $error(msg);

`endif

// ----- rtl/jia_pkg.sv -----
// Types and constants shared by the JVM integer ALU pipeline.
// No dependencies.
package jia_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_REM  = 4'd4,
    OP_NEG  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SHR  = 4'd7,
    OP_USHR = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11
  } jia_op_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned DivSteps = 64;
  localparam logic [5:0] ShamtInt = 6'h1F;
  localparam logic [5:0] ShamtLong = 6'h3F;

  typedef struct packed {
    logic [3:0]  op;
    logic        is_long;
    logic        dz;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] res;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [63:0] dvs;
    logic [63:0] rem;
    logic [63:0] quo;
  } jia_pay_t;

endpackage

// ----- rtl/jia_div_stage.sv -----
// One pipeline stage of the ALU: holds an item and performs one restoring
// division step on it. Depends on jia_pkg.
module jia_div_stage import jia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  jia_pay_t in_pay_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output jia_pay_t out_pay_o
);

  logic     valid_q;
  jia_pay_t pay_q, pay_d;
  logic [64:0] trial;
  logic [64:0] diff;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    trial = {in_pay_i.rem, in_pay_i.quo[63]};
    diff  = trial - {1'b0, in_pay_i.dvs};
    pay_d = in_pay_i;
    pay_d.rem = diff[64] ? trial[63:0] : diff[63:0];
    pay_d.quo = {in_pay_i.quo[62:0], ~diff[64]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pay_q <= pay_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pay_o   = pay_q;

endmodule

// ----- rtl/jvm_integer_alu.sv -----
// Top level of the JVM integer ALU: operand preparation, a chain of
// division stages that also carries every other result, and the output stage.
// Depends on jia_pkg, jia_div_stage and jvm_integer_alu_macros.svh.
`include "jvm_integer_alu_macros.svh"

// Fully pipelined JVM int/long ALU. One bytecode can be transferred in every
// cycle unless a stalled output has filled all stages; each item's transfer
// loads the preparation stage, then 64 division-step stages of the
// one-bit-per-stage restoring divider and one output stage follow. Every
// operation goes through the same stages, so results leave in order. Stages
// with no item fill up behind a stalled output, so input transfers continue
// until all stages are full.
module jvm_integer_alu import jia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic        is_long_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o,
  output logic        divide_by_zero_o
);

  // Preparation stage.
  logic        s0_valid_q;
  jia_pay_t    s0_pay_q, s0_pay_d;
  logic        s0_ready;
  logic [63:0] a, b, abs_a, abs_b;
  logic [5:0]  shamt;
  logic [63:0] p0;
  logic [63:0] p1_full, p2_full;

  always_comb begin
    a = is_long_i ? operand_a_i : {{32{operand_a_i[31]}}, operand_a_i[31:0]};
    b = is_long_i ? operand_b_i : {{32{operand_b_i[31]}}, operand_b_i[31:0]};
    shamt = b[5:0] & (is_long_i ? ShamtLong : ShamtInt);
    abs_a = a[63] ? (64'd0 - a) : a;
    abs_b = b[63] ? (64'd0 - b) : b;
    p0      = a[31:0] * b[31:0];
    p1_full = a[31:0] * b[63:32];
    p2_full = a[63:32] * b[31:0];

    s0_pay_d.op      = action_i;
    s0_pay_d.is_long = is_long_i;
    s0_pay_d.dz      = 1'b0;
    s0_pay_d.neg_q   = a[63] ^ b[63];
    s0_pay_d.neg_r   = a[63];
    s0_pay_d.p1      = p1_full[31:0];
    s0_pay_d.p2      = p2_full[31:0];
    s0_pay_d.dvs     = abs_b;
    s0_pay_d.rem     = 64'd0;
    s0_pay_d.quo     = abs_a;
    case (jia_op_e'(action_i))
      OP_ADD:  s0_pay_d.res = a + b;
      OP_SUB:  s0_pay_d.res = a - b;
      OP_MUL:  s0_pay_d.res = p0;
      OP_DIV, OP_REM: begin
        s0_pay_d.res = 64'd0;
        s0_pay_d.dz  = (b == 64'd0);
      end
      OP_NEG:  s0_pay_d.res = 64'd0 - a;
      OP_SHL:  s0_pay_d.res = a << shamt;
      OP_SHR:  s0_pay_d.res = 64'($signed(a) >>> shamt);
      OP_USHR: s0_pay_d.res = (is_long_i ? a : {32'd0, a[31:0]}) >> shamt;
      OP_AND:  s0_pay_d.res = a & b;
      OP_OR:   s0_pay_d.res = a | b;
      OP_XOR:  s0_pay_d.res = a ^ b;
      default: s0_pay_d.res = 64'd0;
    endcase
  end

  logic     chain_valid [DivSteps+1];
  logic     chain_ready [DivSteps+1];
  jia_pay_t chain_pay   [DivSteps+1];

  assign in_ready_o = !s0_valid_q || s0_ready;
  assign s0_ready   = chain_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_pay_q <= s0_pay_d;
    end
  end

  // The multiply cross terms are folded in beside the first division step.
  always_comb begin
    chain_pay[0] = s0_pay_q;
    if (jia_op_e'(s0_pay_q.op) == OP_MUL) begin
      chain_pay[0].res = s0_pay_q.res + {s0_pay_q.p1 + s0_pay_q.p2, 32'd0};
    end
  end
  assign chain_valid[0] = s0_valid_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    jia_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_pay_i    (chain_pay[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_pay_o   (chain_pay[i+1])
    );
  end

  // Output stage: sign fix-up of quotient and remainder, zero result on divide by zero, int sign extension.
  logic        out_valid_q;
  logic [63:0] result_q, result_d;
  logic        dz_q;
  logic        long_q;
  logic [63:0] raw;
  jia_pay_t    fin;

  assign fin = chain_pay[DivSteps];
  assign chain_ready[DivSteps] = !out_valid_q || out_ready_i;

  always_comb begin
    case (jia_op_e'(fin.op))
      OP_DIV:  raw = fin.neg_q ? (64'd0 - fin.quo) : fin.quo;
      OP_REM:  raw = fin.neg_r ? (64'd0 - fin.rem) : fin.rem;
      default: raw = fin.res;
    endcase
    if (fin.dz) begin
      raw = 64'd0;
    end
    result_d = fin.is_long ? raw : {{32{raw[31]}}, raw[31:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[DivSteps]) begin
      out_valid_q <= chain_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[DivSteps] && chain_valid[DivSteps]) begin
      result_q <= result_d;
      dz_q     <= fin.dz;
      long_q   <= fin.is_long;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = result_q;
  assign divide_by_zero_o = dz_q;

  `JIA_ASSERT(a_dz_zero, out_valid_o && divide_by_zero_o |-> result_o == 64'd0,
              "divide by zero with nonzero result")
  `JIA_ASSERT(a_int_sext, out_valid_o && !long_q |-> result_o[63:32] == {32{result_o[31]}},
              "int result not sign-extended")
  `JIA_ASSERT(a_s0_hold, s0_valid_q && !s0_ready |=> s0_valid_q && $stable(s0_pay_q),
              "preparation stage lost a stalled item")

endmodule

// ----- test/tb.sv -----
// Testbench for jvm_integer_alu: directed table and random bytecodes checked
// against a behavioral predictor of the JVM int/long integer operations.
// Depends on jia_pkg and the jvm_integer_alu RTL.
`timescale 1ns / 1ps

module tb;
  import jia_pkg::*;

  localparam int NumRandom = 1500;
  localparam int LatencyWait = 80;
  localparam int IdleLimit = 20000;
  localparam int MaxReports = 10;

  typedef struct {
    logic [3:0]  op;
    logic        lng;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] res;
    logic        dz;
  } alu_row_t;

  typedef struct {
    logic [63:0] res;
    logic        dz;
  } alu_res_t;

  localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Min32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] AllOnes = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  action_i = '0;
  logic        is_long_i = 1'b0;
  logic [63:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_o;
  logic        divide_by_zero_o;

  alu_res_t pending_results[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       hold_off = 1'b0;
  alu_row_t dir_rows[$];

  jvm_integer_alu dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [63:0] sext_word(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // Behavioral model of one bytecode; int mode works on sign-extended words.
  function automatic alu_res_t alu_predict(logic [3:0] op, logic lng,
                                           logic [63:0] a_in, logic [63:0] b_in);
    alu_res_t r;
    logic [63:0] a, b, v;
    logic signed [63:0] sa, sb;
    int unsigned n;
    a = lng ? a_in : sext_word(a_in);
    b = lng ? b_in : sext_word(b_in);
    sa = a;
    sb = b;
    n = lng ? b[5:0] : b[4:0];
    r.dz = 1'b0;
    v = '0;
    case (op)
      OP_ADD: v = a + b;
      OP_SUB: v = a - b;
      OP_MUL: v = a * b;
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else if (b == AllOnes) begin
          v = (op == OP_DIV) ? -a : '0;
        end else begin
          v = (op == OP_DIV) ? sa / sb : sa % sb;
        end
      end
      OP_NEG: v = -a;
      OP_SHL: v = a << n;
      OP_SHR: v = sa >>> n;
      OP_USHR: v = lng ? (a >> n) : ({32'b0, a[31:0]} >> n);
      OP_AND: v = a & b;
      OP_OR: v = a | b;
      OP_XOR: v = a ^ b;
      default: v = '0;
    endcase
    r.res = lng ? v : sext_word(v);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = AllOnes;
      2: v = $urandom_range(0, 1) ? Min64 : Max64;
      3: v = $urandom_range(0, 1) ? Min32 : 64'h7FFF_FFFF;
      4: v = {{56{v[63]}}, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [3:0] op, logic lng, logic [63:0] a, logic [63:0] b);
    action_i <= op;
    is_long_i <= lng;
    operand_a_i <= a;
    operand_b_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(alu_predict(op, lng, a, b));
    @(negedge clk_i);
  endtask

  task automatic add_row(logic [3:0] op, logic lng, logic [63:0] a, logic [63:0] b,
                         logic known = 1'b0, logic [63:0] res = '0, logic dz = 1'b0);
    alu_row_t row;
    row.op = op; row.lng = lng; row.a = a; row.b = b;
    row.known = known; row.res = res; row.dz = dz;
    dir_rows.push_back(row);
  endtask

  // Sender: directed table, then random bursts, some followed by random gaps.
  initial begin
    int burst;
    alu_res_t typed;
    add_row(OP_ADD, 1'b1, Max64, 64'd1, 1'b1, Min64);
    add_row(OP_ADD, 1'b0, 64'h7FFF_FFFF, 64'd1, 1'b1, Min32);
    add_row(OP_SUB, 1'b1, Min64, 64'd1, 1'b1, Max64);
    add_row(OP_MUL, 1'b1, Min64, AllOnes, 1'b1, Min64);
    add_row(OP_MUL, 1'b0, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_0000_0000_0003);
    add_row(OP_DIV, 1'b1, 64'd7, 64'd0, 1'b1, 64'd0, 1'b1);
    add_row(OP_DIV, 1'b0, 64'd7, 64'hABCD_0000_0000_0000, 1'b1, 64'd0, 1'b1);
    add_row(OP_REM, 1'b1, 64'd7, 64'd0, 1'b1, 64'd0, 1'b1);
    add_row(OP_DIV, 1'b1, Min64, AllOnes, 1'b1, Min64);
    add_row(OP_REM, 1'b1, Min64, AllOnes, 1'b1, 64'd0);
    add_row(OP_DIV, 1'b0, Min32, AllOnes, 1'b1, Min32);
    add_row(OP_REM, 1'b0, Min32, 64'h0000_0000_FFFF_FFFF, 1'b1, 64'd0);
    add_row(OP_DIV, 1'b1, -64'sd7, 64'd2, 1'b1, -64'sd3);
    add_row(OP_REM, 1'b0, -64'sd7, 64'd2, 1'b1, -64'sd1);
    add_row(OP_NEG, 1'b1, Min64, Max64, 1'b1, Min64);
    add_row(OP_NEG, 1'b0, Min32, 64'd5, 1'b1, Min32);
    add_row(OP_SHL, 1'b0, 64'd1, 64'd33, 1'b1, 64'd2);
    add_row(OP_SHL, 1'b1, 64'd1, 64'd63, 1'b1, Min64);
    add_row(OP_SHR, 1'b1, Min64, 64'd127, 1'b1, AllOnes);
    add_row(OP_SHR, 1'b0, Min32, 64'd31, 1'b1, AllOnes);
    add_row(OP_USHR, 1'b0, Min32, 64'd31, 1'b1, 64'd1);
    add_row(OP_USHR, 1'b1, AllOnes, 64'd0, 1'b1, AllOnes);
    add_row(OP_AND, 1'b1, AllOnes, 64'h0F0F, 1'b1, 64'h0F0F);
    add_row(OP_OR, 1'b0, 64'h1_0000_0000, 64'd0, 1'b1, 64'd0);
    add_row(OP_XOR, 1'b1, AllOnes, Max64, 1'b1, Min64);
    add_row(4'd12, 1'b1, AllOnes, AllOnes, 1'b1, 64'd0);
    add_row(4'd15, 1'b0, AllOnes, AllOnes, 1'b1, 64'd0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        typed = alu_predict(dir_rows[i].op, dir_rows[i].lng, dir_rows[i].a, dir_rows[i].b);
        if (typed.res !== dir_rows[i].res || typed.dz !== dir_rows[i].dz)
          $display("Table row %0d disagrees with predictor", i);
      end
      send_item(dir_rows[i].op, dir_rows[i].lng, dir_rows[i].a, dir_rows[i].b);
      // The predictor expectation is replaced by the typed value where given.
      if (dir_rows[i].known) begin
        pending_results[$].res = dir_rows[i].res;
        pending_results[$].dz = dir_rows[i].dz;
      end
    end
    for (int i = 0; i < NumRandom; i += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++)
        send_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), rand64(), rand64());
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: one long hold-off so the pipeline fills, then a stall pattern.
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    repeat (60) @(negedge clk_i);
    hold_off = 1'b1;
    out_ready_i <= 1'b0;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
    forever begin
      @(negedge clk_i);
      phase = (phase + 1) % 64;
      if (phase < 20) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    alu_res_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("Unexpected result %h", result_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o !== exp_r.res || divide_by_zero_o !== exp_r.dz) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("Mismatch: expected result %h dz %b, got result %h dz %b",
                     exp_r.res, exp_r.dz, result_o, divide_by_zero_o);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LatencyWait) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
